FILE: hw/rtl/onboard_charger_current_ramp_defines.svh
// Assertion macros shared by the charger ramp checker.
`ifndef ONBOARD_CHARGER_CURRENT_RAMP_DEFINES_SVH
`define ONBOARD_CHARGER_CURRENT_RAMP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and muted in reset.
`define OCCR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("charger ramp check failed");

// Next-cycle implication, sampled on the rising clock edge and muted in reset.
`define OCCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("charger ramp check failed");

`endif

FILE: hw/rtl/occr_pkg.sv
// Shared constants, types and helper functions of the charger current ramp block.
package occr_pkg;

   // Input item kinds.
   localparam logic [1:0] KIND_FRAME   = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   // Result item kinds.
   localparam logic [1:0] OUT_FRAME   = 2'd0;
   localparam logic [1:0] OUT_ANSWER  = 2'd1;
   localparam logic [1:0] OUT_MEASURE = 2'd2;

   // Measurement codes.
   localparam logic [2:0] MC_LV_VOLTS   = 3'd0;
   localparam logic [2:0] MC_LV_AMPS    = 3'd1;
   localparam logic [2:0] MC_AC_VOLTS   = 3'd2;
   localparam logic [2:0] MC_AC_AMPS    = 3'd3;
   localparam logic [2:0] MC_TEMP       = 3'd4;
   localparam logic [2:0] MC_PILOT_DUTY = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_VOLTAGE_TARGET = 2'd0;
   localparam logic [1:0] CSR_POWER_LIMIT    = 2'd1;

   // Frame identifiers and fixed values.
   localparam logic [10:0] ID_LV       = 11'h377;
   localparam logic [10:0] ID_AC       = 11'h389;
   localparam logic [10:0] ID_STAT     = 11'h38A;
   localparam logic [10:0] ID_ENABLE   = 11'h285;
   localparam logic [10:0] ID_SETPOINT = 11'h286;
   localparam logic [7:0]  ENABLE_BYTE    = 8'hB6;
   localparam logic [7:0]  CURRENT_CAP    = 8'd120;
   localparam logic [7:0]  DUTY_THRESHOLD = 8'd5;
   localparam logic signed [16:0] TEMP_BIAS = 17'sd40;

   // Divider geometry: ten times the power limit over the bus voltage.
   localparam int unsigned DIVIDEND_W  = 20;
   localparam int unsigned DIVISOR_W   = 10;
   localparam int unsigned DIV_COUNT_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [1:0]         out_kind;
      logic [10:0]        tx_id;
      logic [63:0]        tx_payload;
      logic               charge_granted;
      logic               enable_pin;
      logic [2:0]         measure_code;
      logic signed [16:0] measure_value;
      logic               last;
   } result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Build a measurement update word.
   function automatic result_type measure_word(input logic [2:0] code,
                                               input logic signed [16:0] value);
      result_type r;
      r = '0;
      r.out_kind      = OUT_MEASURE;
      r.measure_code  = code;
      r.measure_value = value;
      return r;
   endfunction

   // Build a transmit frame word.
   function automatic result_type frame_word(input logic [10:0] id,
                                             input logic [63:0] payload);
      result_type r;
      r = '0;
      r.out_kind   = OUT_FRAME;
      r.tx_id      = id;
      r.tx_payload = payload;
      return r;
   endfunction

endpackage

FILE: hw/rtl/occr_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
module occr_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [occr_pkg::DIVIDEND_W-1:0]       dividend,
   input  logic [occr_pkg::DIVISOR_W-1:0]        divisor,
   output occr_pkg::div_stat_type                status,
   output logic [occr_pkg::DIVIDEND_W-1:0]       quotient
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [occr_pkg::DIV_COUNT_W-1:0]      count_ff, count_in;
   logic [occr_pkg::DIVISOR_W-1:0]        rem_ff, rem_in;
   logic [occr_pkg::DIVIDEND_W-1:0]       quo_ff, quo_in;
   logic [occr_pkg::DIVISOR_W-1:0]        dvs_ff, dvs_in;
   logic [occr_pkg::DIVISOR_W:0]          shifted;
   logic [occr_pkg::DIVISOR_W:0]          diff;
   logic                                  fits;

   // One restoring step: bring in the next dividend bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[occr_pkg::DIVIDEND_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = occr_pkg::DIV_COUNT_W'(occr_pkg::DIVIDEND_W - 1);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[occr_pkg::DIVISOR_W-1:0] : shifted[occr_pkg::DIVISOR_W-1:0];
         quo_in   = {quo_ff[occr_pkg::DIVIDEND_W-2:0], fits};
         count_in = count_ff - occr_pkg::DIV_COUNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

FILE: hw/rtl/onboard_charger_current_ramp.sv
// Charger current ramp controller: top level with item decoder, ramp state and result queue.
//
// Usage: the req_ channel carries one item (received frame, charge request or
// 100 ms tick); the rsp_ channel returns zero, one or two result words per
// item, the final one marked by rsp_last. A word moves when valid is high and
// stall is low. The csr_ port writes voltage_target (index 0) and power_limit
// (index 1); write it only while the block is idle.
// The first result word of a frame or request item appears in the cycle after
// acceptance. A granted tick with a nonzero bus voltage runs the serial
// power-over-voltage divider, one quotient bit per cycle, then passes through
// the ramp update state before its first word is offered; with a zero bus
// voltage the divide is skipped and the tick goes straight to the update state.
// The block works on one item at a time: for an item with result words,
// req_stall stays high from acceptance until the last result word is taken.
// Reset (synchronous, active high) clears the sequencer state, the
// configuration registers, the grant, the session flag, the ramp and the stored
// pilot duty; the result words and the latched bus voltage are not reset. While
// rsp_stall is high the pending word holds and no new item is taken.
module onboard_charger_current_ramp (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [10:0]        req_rx_id,
   input  logic [63:0]        req_rx_payload,
   input  logic               req_run_wanted,
   input  logic               req_ac_wanted,
   input  logic [9:0]         req_bus_volts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_kind,
   output logic [10:0]        rsp_tx_id,
   output logic [63:0]        rsp_tx_payload,
   output logic               rsp_charge_granted,
   output logic               rsp_enable_pin,
   output logic [2:0]         rsp_measure_code,
   output logic signed [16:0] rsp_measure_value,
   output logic               rsp_last,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   occr_pkg::state_type  state_ff, state_in;
   logic [9:0]           vt_ff, vt_in;
   logic [15:0]          pl_ff, pl_in;
   logic                 granted_ff, granted_in;
   logic                 session_ff, session_in;
   logic [7:0]           ramp_ff, ramp_in;
   logic [7:0]           duty_ff, duty_in;
   logic                 idx_ff, idx_in;
   logic                 two_ff, two_in;
   logic [9:0]           bus_ff, bus_in;
   occr_pkg::result_type res_ff [2];
   occr_pkg::result_type res_in [2];
   occr_pkg::result_type rsp_word;

   logic                               accept;
   logic [7:0]                         b0, b1, b2, b3, b6, hot;
   logic                               grant_now;
   logic [13:0]                        setv;
   logic                               div_start;
   logic [occr_pkg::DIVIDEND_W-1:0]    dividend;
   occr_pkg::div_stat_type             div_status;
   logic [occr_pkg::DIVIDEND_W-1:0]    quotient;
   logic [7:0]                         cmax;
   logic [7:0]                         step;

   assign accept = req_valid && !req_stall;

   // Payload bytes used by the frame decoder.
   assign b0  = req_rx_payload[7:0];
   assign b1  = req_rx_payload[15:8];
   assign b2  = req_rx_payload[23:16];
   assign b3  = req_rx_payload[31:24];
   assign b6  = req_rx_payload[55:48];
   assign hot = (b0 > b1) ? b0 : b1;

   assign grant_now = req_run_wanted && req_ac_wanted && (duty_ff > occr_pkg::DUTY_THRESHOLD);

   // Voltage setpoint in tenths of a volt: target times ten as shift and add.
   assign setv = {1'b0, vt_ff, 3'b000} + {3'b000, vt_ff, 1'b0};

   // Ten times the power limit, the divider's dividend.
   assign dividend = {1'b0, pl_ff, 3'b000} + {3'b000, pl_ff, 1'b0};

   assign div_start = accept && (req_kind == occr_pkg::KIND_TICK) && granted_ff
                      && (req_bus_volts != '0);

   occr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (req_bus_volts),
      .status   (div_status),
      .quotient (quotient)
   );

   // Power-limited maximum, then one ramp step with saturation at both ends.
   always_comb begin
      if (bus_ff == '0) begin
         cmax = '0;
      end else if (quotient > occr_pkg::DIVIDEND_W'(occr_pkg::CURRENT_CAP)) begin
         cmax = occr_pkg::CURRENT_CAP;
      end else begin
         cmax = quotient[7:0];
      end
      if (bus_ff < vt_ff) begin
         step = (ramp_ff == 8'hFF) ? ramp_ff : ramp_ff + 8'd1;
      end else begin
         step = (ramp_ff == 8'h00) ? ramp_ff : ramp_ff - 8'd1;
      end
   end

   // Configuration writes; indexes beyond the list are dropped.
   always_comb begin
      vt_in = vt_ff;
      pl_in = pl_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            occr_pkg::CSR_VOLTAGE_TARGET: vt_in = csr_wdata[9:0];
            occr_pkg::CSR_POWER_LIMIT:    pl_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Item decoder and sequencer.
   always_comb begin
      state_in   = state_ff;
      granted_in = granted_ff;
      session_in = session_ff;
      ramp_in    = ramp_ff;
      duty_in    = duty_ff;
      idx_in     = idx_ff;
      two_in     = two_ff;
      bus_in     = bus_ff;
      res_in[0]  = res_ff[0];
      res_in[1]  = res_ff[1];
      unique case (state_ff)
         occr_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in = 1'b0;
               bus_in = req_bus_volts;
               case (req_kind)
                  occr_pkg::KIND_FRAME: begin
                     two_in = 1'b1;
                     if (req_rx_id == occr_pkg::ID_LV) begin
                        res_in[0] = occr_pkg::measure_word(occr_pkg::MC_LV_VOLTS,
                                                           {1'b0, b0, b1});
                        res_in[1] = occr_pkg::measure_word(occr_pkg::MC_LV_AMPS,
                                                           {1'b0, b2, b3});
                        state_in  = occr_pkg::ST_SEND;
                     end else if (req_rx_id == occr_pkg::ID_AC) begin
                        res_in[0] = occr_pkg::measure_word(occr_pkg::MC_AC_VOLTS,
                                                           {9'd0, b1});
                        res_in[1] = occr_pkg::measure_word(occr_pkg::MC_AC_AMPS,
                                                           {9'd0, b6});
                        state_in  = occr_pkg::ST_SEND;
                     end else if (req_rx_id == occr_pkg::ID_STAT) begin
                        duty_in   = b3;
                        res_in[0] = occr_pkg::measure_word(occr_pkg::MC_TEMP,
                                       $signed({9'd0, hot}) - occr_pkg::TEMP_BIAS);
                        res_in[1] = occr_pkg::measure_word(occr_pkg::MC_PILOT_DUTY,
                                                           {9'd0, b3});
                        state_in  = occr_pkg::ST_SEND;
                     end
                     res_in[0].last = 1'b0;
                     res_in[1].last = 1'b1;
                  end
                  occr_pkg::KIND_REQUEST: begin
                     granted_in = grant_now;
                     two_in     = grant_now;
                     res_in[0]  = '0;
                     res_in[0].out_kind       = occr_pkg::OUT_ANSWER;
                     res_in[0].charge_granted = grant_now;
                     res_in[0].enable_pin     = grant_now;
                     res_in[0].last           = !grant_now;
                     res_in[1] = occr_pkg::measure_word(occr_pkg::MC_PILOT_DUTY,
                                                        {9'd0, duty_ff});
                     res_in[1].last = 1'b1;
                     state_in  = occr_pkg::ST_SEND;
                  end
                  occr_pkg::KIND_TICK: begin
                     if (granted_ff) begin
                        session_in = 1'b1;
                        two_in     = 1'b1;
                        res_in[0]  = occr_pkg::frame_word(occr_pkg::ID_ENABLE,
                                        {40'd0, occr_pkg::ENABLE_BYTE, 16'd0});
                        res_in[1]  = occr_pkg::frame_word(occr_pkg::ID_SETPOINT,
                                        {40'd0, ramp_ff, setv[7:0], 2'b00, setv[13:8]});
                        res_in[0].last = 1'b0;
                        res_in[1].last = 1'b1;
                        state_in = (req_bus_volts == '0) ? occr_pkg::ST_UPDATE
                                                         : occr_pkg::ST_DIVIDE;
                     end else if (session_ff) begin
                        ramp_in    = '0;
                        session_in = 1'b0;
                        two_in     = 1'b0;
                        res_in[0]  = occr_pkg::frame_word(occr_pkg::ID_SETPOINT, 64'd0);
                        res_in[0].last = 1'b1;
                        state_in   = occr_pkg::ST_SEND;
                     end else begin
                        ramp_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         occr_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = occr_pkg::ST_UPDATE;
            end
         end
         occr_pkg::ST_UPDATE: begin
            ramp_in  = (step >= cmax) ? cmax : step;
            state_in = occr_pkg::ST_SEND;
         end
         occr_pkg::ST_SEND: begin
            if (!rsp_stall) begin
               if (!idx_ff && two_ff) begin
                  idx_in = 1'b1;
               end else begin
                  state_in = occr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = occr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= occr_pkg::ST_IDLE;
         vt_ff      <= '0;
         pl_ff      <= '0;
         granted_ff <= 1'b0;
         session_ff <= 1'b0;
         ramp_ff    <= '0;
         duty_ff    <= '0;
         idx_ff     <= 1'b0;
         two_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vt_ff      <= vt_in;
         pl_ff      <= pl_in;
         granted_ff <= granted_in;
         session_ff <= session_in;
         ramp_ff    <= ramp_in;
         duty_ff    <= duty_in;
         idx_ff     <= idx_in;
         two_ff     <= two_in;
      end
   end

   // Result words and the latched bus voltage.
   always_ff @(posedge clock) begin
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
      bus_ff    <= bus_in;
   end

   // Output port drive.
   assign req_stall          = (state_ff != occr_pkg::ST_IDLE);
   assign rsp_valid          = (state_ff == occr_pkg::ST_SEND);
   assign rsp_word           = res_ff[idx_ff];
   assign rsp_out_kind       = rsp_word.out_kind;
   assign rsp_tx_id          = rsp_word.tx_id;
   assign rsp_tx_payload     = rsp_word.tx_payload;
   assign rsp_charge_granted = rsp_word.charge_granted;
   assign rsp_enable_pin     = rsp_word.enable_pin;
   assign rsp_measure_code   = rsp_word.measure_code;
   assign rsp_measure_value  = rsp_word.measure_value;
   assign rsp_last           = rsp_word.last;

endmodule

FILE: hw/rtl/occr_checker.sv
// Port-level checker for the charger current ramp block and its bind.
`include "onboard_charger_current_ramp_defines.svh"

module occr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_out_kind,
   input logic [10:0]        rsp_tx_id,
   input logic [63:0]        rsp_tx_payload,
   input logic               rsp_charge_granted,
   input logic               rsp_enable_pin,
   input logic [2:0]         rsp_measure_code,
   input logic signed [16:0] rsp_measure_value,
   input logic               rsp_last
);

   // No new item is taken while a result word is pending.
   `OCCR_ASSERT_NOW(a_busy_while_rsp, rsp_valid, req_stall)

   // A stalled result word stays offered and unchanged.
   `OCCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_kind) && $stable(rsp_tx_id)
      && $stable(rsp_tx_payload) && $stable(rsp_charge_granted)
      && $stable(rsp_enable_pin) && $stable(rsp_measure_code)
      && $stable(rsp_measure_value) && $stable(rsp_last))

   // A charge answer drives the enable pin to the grant level.
   `OCCR_ASSERT_NOW(a_answer_pin, rsp_valid && rsp_out_kind == occr_pkg::OUT_ANSWER,
      rsp_charge_granted == rsp_enable_pin)

   // A refused request produces the answer word alone.
   `OCCR_ASSERT_NOW(a_refusal_last,
      rsp_valid && rsp_out_kind == occr_pkg::OUT_ANSWER && !rsp_charge_granted, rsp_last)

endmodule

bind onboard_charger_current_ramp occr_checker u_occr_checker (.*);
